>>> hdl/tfst_pkg.sv
// ============================================================================
// tfst_pkg
// Shared types and constants of the TCP flow session tracker: header check
// limits, action codes, flow key layout and controller/datapath handshake.
// ============================================================================
`default_nettype none

package tfst_pkg;

  // Action codes of an input word
  localparam logic ACT_PACKET = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  // Header check limits
  localparam logic [3:0] IP_VERSION_V4 = 4'h4;
  localparam logic [3:0] MIN_HDR_WORDS = 4'd5;

  // Four-tuple of a flow
  typedef struct packed {
    logic [31:0] saddr;
    logic [31:0] daddr;
    logic [15:0] sport;
    logic [15:0] dport;
  } flow_key_t;

  // One table entry
  typedef struct packed {
    logic      vld;
    flow_key_t key;
  } flow_entry_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture the word, rewind the address
    logic sweep;   // write an invalid entry at the address, advance
    logic scan;    // read the entry at the address, advance
    logic update;  // commit table change and issue the result
  } fsm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_clear;   // word at the ports is a clear action
    logic in_hdr_ok;  // header at the ports passes the checks
    logic addr_last;  // address is at the last entry
  } fsm_sts_t;

endpackage

`default_nettype wire

>>> hdl/tfst_ctrl.sv
// ============================================================================
// tfst_ctrl
// Sequencer of the flow tracker: init sweep after reset, clear sweep,
// table scan, and the final update/result cycle.
// ============================================================================
`default_nettype none

module tfst_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire tfst_pkg::fsm_sts_t sts,
  output tfst_pkg::fsm_cmd_t     cmd,
  output logic                   busy
);

  tfst_pkg::ctrl_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tfst_pkg::ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tfst_pkg::ST_INIT: begin
        if (sts.addr_last) state_nxt = tfst_pkg::ST_IDLE;
      end
      tfst_pkg::ST_IDLE: begin
        if (start) begin
          if (sts.in_clear)       state_nxt = tfst_pkg::ST_CLEAR;
          else if (sts.in_hdr_ok) state_nxt = tfst_pkg::ST_SCAN;
          else                    state_nxt = tfst_pkg::ST_UPDATE;
        end
      end
      tfst_pkg::ST_CLEAR: begin
        if (sts.addr_last) state_nxt = tfst_pkg::ST_UPDATE;
      end
      tfst_pkg::ST_SCAN: begin
        if (sts.addr_last) state_nxt = tfst_pkg::ST_DRAIN;
      end
      tfst_pkg::ST_DRAIN:  state_nxt = tfst_pkg::ST_UPDATE;
      tfst_pkg::ST_UPDATE: state_nxt = tfst_pkg::ST_IDLE;
      default:             state_nxt = tfst_pkg::ST_INIT;
    endcase
  end

  // Commands
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      tfst_pkg::ST_INIT:   cmd.sweep = 1'b1;
      tfst_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      tfst_pkg::ST_CLEAR:  cmd.sweep  = 1'b1;
      tfst_pkg::ST_SCAN:   cmd.scan   = 1'b1;
      tfst_pkg::ST_DRAIN:  cmd        = '0;
      tfst_pkg::ST_UPDATE: cmd.update = 1'b1;
      default:             cmd        = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/tfst_datapath.sv
// ============================================================================
// tfst_datapath
// Flow table memory, header check, scan address, hit/free tracking and
// the result register.
// ============================================================================
`default_nettype none

module tfst_datapath #(
  parameter int FLOW_ENTRIES = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tfst_pkg::fsm_cmd_t cmd,
  output tfst_pkg::fsm_sts_t      sts,
  input  wire logic               in_action,
  input  wire logic [15:0]        in_packet_length,
  input  wire logic [3:0]         in_ip_version,
  input  wire logic [3:0]         in_ip_header_words,
  input  wire logic [3:0]         in_tcp_offset_words,
  input  wire logic [31:0]        in_source_address,
  input  wire logic [31:0]        in_dest_address,
  input  wire logic [15:0]        in_source_port,
  input  wire logic [15:0]        in_dest_port,
  input  wire logic               in_fin_flag,
  input  wire logic               in_rst_flag,
  output logic                    out_strobe,
  output logic                    out_forward_packet,
  output logic                    out_send_decoy,
  output logic                    out_table_overflow
);

  localparam int IDX_W = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FLOW_ENTRIES - 1);

  tfst_pkg::flow_entry_t mem [FLOW_ENTRIES];

  logic [IDX_W-1:0]      addr_r;
  tfst_pkg::flow_key_t   key_r;
  logic                  done_r;
  logic                  pkt_ok_r;
  tfst_pkg::flow_entry_t rd_data_r;
  logic [IDX_W-1:0]      rd_idx_r;
  logic                  rd_vld_r;
  logic                  hit_found_r;
  logic [IDX_W-1:0]      hit_idx_r;
  logic                  free_found_r;
  logic [IDX_W-1:0]      free_idx_r;
  logic                  strobe_r;
  logic                  fwd_r, decoy_r, ovf_r;

  logic [4:0]            hdr_words;
  logic [6:0]            hdr_bytes;
  logic                  key_match;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  tfst_pkg::flow_entry_t wr_data;
  logic                  upd_write;

  // Header check on the port word: both headers at least 5 words, length covers both
  assign hdr_words = {1'b0, in_ip_header_words} + {1'b0, in_tcp_offset_words};
  assign hdr_bytes = {hdr_words, 2'b00};
  assign sts.in_hdr_ok = (in_ip_version == tfst_pkg::IP_VERSION_V4)
                       && (in_ip_header_words >= tfst_pkg::MIN_HDR_WORDS)
                       && (in_tcp_offset_words >= tfst_pkg::MIN_HDR_WORDS)
                       && (in_packet_length >= {9'd0, hdr_bytes});
  assign sts.in_clear  = (in_action == tfst_pkg::ACT_CLEAR);
  assign sts.addr_last = (addr_r == LAST_IDX);

  // Sweep / scan address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
    end else if (cmd.load) begin
      addr_r <= '0;
    end else if (cmd.sweep || cmd.scan) begin
      addr_r <= sts.addr_last ? '0 : addr_r + IDX_W'(1);
    end
  end

  // Captured word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r.saddr <= in_source_address;
      key_r.daddr <= in_dest_address;
      key_r.sport <= in_source_port;
      key_r.dport <= in_dest_port;
      done_r      <= in_fin_flag | in_rst_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkt_ok_r <= 1'b0;
    end else if (cmd.load) begin
      pkt_ok_r <= !sts.in_clear && sts.in_hdr_ok;
    end
  end

  // Table write port: sweep clears, update commits
  assign upd_write = pkt_ok_r && (hit_found_r ? done_r : free_found_r);
  assign wr_en     = cmd.sweep || (cmd.update && upd_write);
  assign wr_addr   = cmd.sweep ? addr_r : (hit_found_r ? hit_idx_r : free_idx_r);
  always_comb begin
    wr_data.key = key_r;
    wr_data.vld = !cmd.sweep && !hit_found_r && !done_r;
  end

  // Table memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[addr_r];
    rd_idx_r  <= addr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan;
    end
  end

  // First valid match and first free entry
  assign key_match = (rd_data_r.key == key_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
    end else if (cmd.load) begin
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
    end else if (rd_vld_r) begin
      if (rd_data_r.vld) begin
        if (!hit_found_r && key_match) begin
          hit_found_r <= 1'b1;
        end
      end else if (!free_found_r) begin
        free_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r && rd_data_r.vld && !hit_found_r && key_match) begin
      hit_idx_r <= rd_idx_r;
    end
    if (rd_vld_r && !rd_data_r.vld && !free_found_r) begin
      free_idx_r <= rd_idx_r;
    end
  end

  // Result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd.update;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      fwd_r   <= pkt_ok_r;
      decoy_r <= pkt_ok_r && !hit_found_r;
      ovf_r   <= pkt_ok_r && !hit_found_r && !free_found_r;
    end
  end

  assign out_strobe         = strobe_r;
  assign out_forward_packet = fwd_r;
  assign out_send_decoy     = decoy_r;
  assign out_table_overflow = ovf_r;

endmodule

`default_nettype wire

>>> hdl/tcp_flow_session_tracker.sv
// ============================================================================
// tcp_flow_session_tracker
// Tracks outbound IPv4/TCP flows in a table searched by four-tuple. A new
// flow is inserted and asks for a decoy; FIN or RST removes the flow; a full
// table flags overflow; a clear action empties the table.
//
//   channel   ports                     handshake
//   input     start, busy, in_*         taken when start=1 and busy=0
//   result    out_strobe, out_*         one word per strobe cycle, no stall
//
// Work per word (N = FLOW_ENTRIES), accept to strobe:
//   valid packet   linear scan of all N entries, one table read per cycle,
//                  then drain and update states; busy clears when the strobe rises
//   clear action   sweep writes one entry per cycle, then the update state
//   malformed      update state only
// After reset the block stays busy while it clears the table.
// The result side cannot stall; each word is shown for one cycle only.
// ============================================================================
`default_nettype none

module tcp_flow_session_tracker #(
  parameter int FLOW_ENTRIES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_action,
  input  wire logic [15:0] in_packet_length,
  input  wire logic [3:0]  in_ip_version,
  input  wire logic [3:0]  in_ip_header_words,
  input  wire logic [3:0]  in_tcp_offset_words,
  input  wire logic [31:0] in_source_address,
  input  wire logic [31:0] in_dest_address,
  input  wire logic [15:0] in_source_port,
  input  wire logic [15:0] in_dest_port,
  input  wire logic        in_fin_flag,
  input  wire logic        in_rst_flag,
  output logic             out_strobe,
  output logic             out_forward_packet,
  output logic             out_send_decoy,
  output logic             out_table_overflow
);

  tfst_pkg::fsm_cmd_t cmd;
  tfst_pkg::fsm_sts_t sts;

  // Sequencer
  tfst_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Table and result datapath
  tfst_datapath #(
    .FLOW_ENTRIES (FLOW_ENTRIES)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_action           (in_action),
    .in_packet_length    (in_packet_length),
    .in_ip_version       (in_ip_version),
    .in_ip_header_words  (in_ip_header_words),
    .in_tcp_offset_words (in_tcp_offset_words),
    .in_source_address   (in_source_address),
    .in_dest_address     (in_dest_address),
    .in_source_port      (in_source_port),
    .in_dest_port        (in_dest_port),
    .in_fin_flag         (in_fin_flag),
    .in_rst_flag         (in_rst_flag),
    .out_strobe          (out_strobe),
    .out_forward_packet  (out_forward_packet),
    .out_send_decoy      (out_send_decoy),
    .out_table_overflow  (out_table_overflow)
  );

endmodule

`default_nettype wire

>>> hdl/tfst_checker.sv
// ============================================================================
// tfst_checker
// Port-level checks of the flow tracker, bound to the top level.
// ============================================================================
`default_nettype none

module tfst_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_strobe,
  input wire logic out_forward_packet,
  input wire logic out_send_decoy,
  input wire logic out_table_overflow
);

  // An accepted word keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy low after accept");

  // A result ends the work on its word
  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (!busy && $past(busy)))
    else $error("result without a finished word");

  // Results never come in consecutive cycles
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("back-to-back result words");

  // Overflow implies a decoy for a forwarded packet
  a_overflow_decoy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_table_overflow) |-> (out_send_decoy && out_forward_packet))
    else $error("overflow without decoy");

  // A decoy only goes ahead of a forwarded packet
  a_decoy_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_send_decoy) |-> out_forward_packet)
    else $error("decoy on a dropped packet");

endmodule

bind tcp_flow_session_tracker tfst_checker u_tfst_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_strobe         (out_strobe),
  .out_forward_packet (out_forward_packet),
  .out_send_decoy     (out_send_decoy),
  .out_table_overflow (out_table_overflow)
);

`default_nettype wire
